// ----- sv/mau_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mau_pkg
// Shared widths, operation codes and the multiplier status type for the
// modular arithmetic unit.
// ----------------------------------------------------------------------------
package mau_pkg;

  localparam int MOD_WIDTH_DEFAULT = 31;
  localparam int OPERAND_WIDTH     = 63;
  localparam int RESULT_WIDTH      = 31;
  localparam int OP_WIDTH          = 3;
  localparam int BIT_CNT_WIDTH     = $clog2(OPERAND_WIDTH);

  localparam logic [RESULT_WIDTH-1:0]  MOD_RESET = 31'd1000000007;
  localparam logic [BIT_CNT_WIDTH-1:0] BIT_LAST  = BIT_CNT_WIDTH'(OPERAND_WIDTH - 1);

  localparam logic [OP_WIDTH-1:0] OP_ADD = 3'd0;
  localparam logic [OP_WIDTH-1:0] OP_SUB = 3'd1;
  localparam logic [OP_WIDTH-1:0] OP_MUL = 3'd2;
  localparam logic [OP_WIDTH-1:0] OP_POW = 3'd3;
  localparam logic [OP_WIDTH-1:0] OP_INV = 3'd4;

  typedef struct packed {
    logic busy;
    logic done;
  } mau_mul_status_t;

endpackage
`default_nettype wire

// ----- sv/mau_mulmod.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mau_mulmod
// Bit-serial modular multiplier: double-and-add over the bits of y, one bit
// per cycle, with the running value kept below the modulus.
// ----------------------------------------------------------------------------
module mau_mulmod
  import mau_pkg::*;
#(
  parameter int W = MOD_WIDTH_DEFAULT
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [W-1:0]    x,
  input  wire logic [W-1:0]    y,
  input  wire logic [W-1:0]    m,
  output mau_mul_status_t      status,
  output logic      [W-1:0]    p
);

  localparam int CW = $clog2(W);

  logic          busy;
  logic          done;
  logic [CW-1:0] cnt;
  logic [W-1:0]  xr;
  logic [W-1:0]  yr;
  logic [W-1:0]  acc;
  logic [W-1:0]  acc_next;
  logic [W+1:0]  t;
  logic [W+1:0]  m1;
  logic [W+1:0]  m2;

  // 2*acc + x stays below 3m, so one of three candidates is the reduced value.
  always_comb begin
    m1 = {2'b00, m};
    m2 = {1'b0, m, 1'b0};
    t  = {1'b0, acc, 1'b0} + (yr[W-1] ? {2'b00, xr} : '0);
    if (t >= m2) begin
      acc_next = W'(t - m2);
    end else if (t >= m1) begin
      acc_next = W'(t - m1);
    end else begin
      acc_next = t[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xr  <= x;
      yr  <= y;
      acc <= '0;
    end else if (busy) begin
      acc <= acc_next;
      yr  <= {yr[W-2:0], 1'b0};
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign p           = acc;

endmodule
`default_nettype wire

// ----- sv/modular_arithmetic_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// modular_arithmetic_unit
// Add, subtract, multiply, power and Fermat inverse modulo a programmable
// modulus, built from bit-serial reduction and multiplication.
// ----------------------------------------------------------------------------
// One request is processed at a time. Both operands are first reduced by a
// bit-serial shift-and-subtract over their 63 bits, then the operation runs:
// add and subtract are done in the execute state, multiply runs in the serial
// multiplier, and power and inverse walk all 63 exponent bits with a square
// and, for a set bit, a multiply. The finish state then loads the result
// register; the next request is taken while that result waits to be read.
// A modulus below two, or an unused operation code, returns 0. The modulus
// may only be written while the unit is idle.
// ----------------------------------------------------------------------------
module modular_arithmetic_unit
  import mau_pkg::*;
#(
  parameter int MOD_WIDTH = MOD_WIDTH_DEFAULT
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [RESULT_WIDTH-1:0]  cfg_data,
  input  wire logic                     op_valid,
  output logic                          op_stall,
  input  wire logic [OP_WIDTH-1:0]      operation,
  input  wire logic [OPERAND_WIDTH-1:0] operand_a,
  input  wire logic [OPERAND_WIDTH-1:0] operand_b,
  output logic                          res_valid,
  input  wire logic                     res_stall,
  output logic [RESULT_WIDTH-1:0]       result
);

  localparam int W = MOD_WIDTH;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RED  = 4'd1;
  localparam logic [3:0] S_EXEC = 4'd2;
  localparam logic [3:0] S_MUL  = 4'd3;
  localparam logic [3:0] S_SQ   = 4'd4;
  localparam logic [3:0] S_SQW  = 4'd5;
  localparam logic [3:0] S_ML   = 4'd6;
  localparam logic [3:0] S_MLW  = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  logic [3:0]               state;
  logic [BIT_CNT_WIDTH-1:0] cnt;
  logic [OP_WIDTH-1:0]      op_q;
  logic [OPERAND_WIDTH-1:0] sa;
  logic [OPERAND_WIDTH-1:0] sb;
  logic [OPERAND_WIDTH-1:0] expo;
  logic [W-1:0]             modulus;
  logic [W-1:0]             ra;
  logic [W-1:0]             rb;
  logic [W-1:0]             acc;
  logic [W-1:0]             res_q;
  logic [W-1:0]             res_data;
  logic [W-1:0]             ra_next;
  logic [W-1:0]             rb_next;
  logic [W-1:0]             sum_red;
  logic [W-1:0]             diff_red;
  logic [W:0]               ta;
  logic [W:0]               tb;
  logic [W:0]               sum;
  logic [W:0]               mod_ext;
  logic                     mod_ok;
  logic                     accept;
  logic                     res_free;
  logic                     mul_start;
  logic [W-1:0]             mul_x;
  logic [W-1:0]             mul_y;
  logic [W-1:0]             mul_p;
  mau_mul_status_t          mul_st;

  assign accept    = op_valid && !op_stall;
  assign op_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign mod_ok    = (modulus >= W'(2));
  assign mod_ext   = {1'b0, modulus};
  assign res_free  = !res_valid || !res_stall;
  assign result    = RESULT_WIDTH'(res_data);

  // One shift-and-subtract step of each operand reduction.
  always_comb begin
    ta = {ra, sa[OPERAND_WIDTH-1]};
    tb = {rb, sb[OPERAND_WIDTH-1]};
    ra_next = (ta >= mod_ext) ? W'(ta - mod_ext) : ta[W-1:0];
    rb_next = (tb >= mod_ext) ? W'(tb - mod_ext) : tb[W-1:0];
  end

  always_comb begin
    sum      = {1'b0, ra} + {1'b0, rb};
    sum_red  = (sum >= mod_ext) ? W'(sum - mod_ext) : sum[W-1:0];
    diff_red = (ra >= rb) ? (ra - rb) : W'({1'b0, ra} + mod_ext - {1'b0, rb});
  end

  always_comb begin
    mul_start = (state == S_SQ) || (state == S_ML) ||
                ((state == S_EXEC) && mod_ok && (op_q == OP_MUL));
    mul_x = acc;
    mul_y = acc;
    if (state == S_EXEC) begin
      mul_x = ra;
      mul_y = rb;
    end else if (state == S_ML) begin
      mul_x = ra;
    end
  end

  mau_mulmod #(
    .W (W)
  ) u_mulmod (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .x      (mul_x),
    .y      (mul_y),
    .m      (modulus),
    .status (mul_st),
    .p      (mul_p)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      modulus   <= W'(MOD_RESET);
      res_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        modulus <= cfg_data[W-1:0];
      end
      if ((state == S_FIN) && res_free) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: if (accept) state <= S_RED;
        S_RED:  if (cnt == '0) state <= S_EXEC;
        S_EXEC: begin
          if (!mod_ok) begin
            state <= S_FIN;
          end else begin
            unique case (op_q) inside
              OP_MUL:         state <= S_MUL;
              OP_POW, OP_INV: state <= S_SQ;
              default:        state <= S_FIN;
            endcase
          end
        end
        S_MUL:  if (mul_st.done) state <= S_FIN;
        S_SQ:   state <= S_SQW;
        S_SQW: begin
          if (mul_st.done) begin
            if (expo[OPERAND_WIDTH-1]) state <= S_ML;
            else if (cnt == '0)        state <= S_FIN;
            else                       state <= S_SQ;
          end
        end
        S_ML:   state <= S_MLW;
        S_MLW: begin
          if (mul_st.done) state <= (cnt == '0) ? S_FIN : S_SQ;
        end
        S_FIN:  if (res_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          op_q <= operation;
          sa   <= operand_a;
          sb   <= operand_b;
          expo <= operand_b;
          ra   <= '0;
          rb   <= '0;
          cnt  <= BIT_LAST;
        end
      end
      S_RED: begin
        ra  <= ra_next;
        rb  <= rb_next;
        sa  <= {sa[OPERAND_WIDTH-2:0], 1'b0};
        sb  <= {sb[OPERAND_WIDTH-2:0], 1'b0};
        cnt <= cnt - 1'b1;
      end
      S_EXEC: begin
        res_q <= '0;
        acc   <= W'(1);
        cnt   <= BIT_LAST;
        if (op_q == OP_INV) begin
          expo <= OPERAND_WIDTH'(modulus - W'(2));
        end
        if (mod_ok) begin
          if (op_q == OP_ADD) res_q <= sum_red;
          if (op_q == OP_SUB) res_q <= diff_red;
        end
      end
      S_MUL: begin
        if (mul_st.done) res_q <= mul_p;
      end
      S_SQW: begin
        if (mul_st.done) begin
          acc <= mul_p;
          res_q <= mul_p;
          if (!expo[OPERAND_WIDTH-1]) begin
            expo <= {expo[OPERAND_WIDTH-2:0], 1'b0};
            cnt  <= cnt - 1'b1;
          end
        end
      end
      S_MLW: begin
        if (mul_st.done) begin
          acc   <= mul_p;
          res_q <= mul_p;
          expo  <= {expo[OPERAND_WIDTH-2:0], 1'b0};
          cnt   <= cnt - 1'b1;
        end
      end
      // The output register holds its value while the next request runs.
      S_FIN: begin
        if (res_free) res_data <= res_q;
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  // The multiplier only runs while the sequencer waits for it.
  a_mul_owned: assert property (@(posedge clk) disable iff (rst)
    (mul_st.busy || mul_st.done) |->
      (state == S_MUL || state == S_SQW || state == S_MLW))
    else $error("multiplier active outside a wait state");

  a_accept_reduces: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_RED))
    else $error("accepted request did not start reduction");

  a_fin_delivers: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && res_free) |=> (res_valid && state == S_IDLE))
    else $error("finished result not loaded into the output register");
`endif

endmodule
`default_nettype wire
